// ===== rtl/assert_macros.svh =====
// Assertion helpers for the sparse matrix-vector accumulator.
// All properties sample on clk_i and are off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LSMA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lsma assertion failed");
`define LSMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsma assertion failed");
`else
`define LSMA_ASSERT(lbl, prop)
`define LSMA_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== rtl/lsma_pkg.sv =====
package lsma_pkg;

  // default sizes of the vector stores
  localparam int unsigned MAX_VERTICES_DEF   = 4096;
  localparam int unsigned MAX_COMPONENTS_DEF = 4;

  // item opcodes
  typedef enum logic [2:0] {
    OP_LOAD_X = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_DIAG   = 3'd2,
    OP_EDGE   = 3'd3,
    OP_READ   = 3'd4
  } lsma_op_e;

  // register index (paddr bit 2)
  localparam logic REG_COMPONENTS = 1'b0;
  localparam logic REG_LOWER      = 1'b1;

  // quiet NaN produced by invalid operations
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  // item sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_FSTART,
    S_FWAIT,
    S_RDOUT
  } lsma_state_e;

  // multiply-add unit sequencer
  typedef enum logic [3:0] {
    F_IDLE,
    F_MSET,
    F_MUL,
    F_NORM,
    F_DEN,
    F_RND,
    F_ASET,
    F_ALIGN,
    F_ADD,
    F_DONE
  } lsma_fstate_e;

  typedef struct packed {
    logic        start;
    logic [63:0] coef;
    logic [63:0] xval;
    logic [63:0] bval;
  } lsma_fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } lsma_fpu_rsp_t;

endpackage

// ===== rtl/lsma_fpu.sv =====
`include "assert_macros.svh"
// Iterative double multiply-add: result = b + coef * x, product rounded, then sum rounded.
module lsma_fpu (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lsma_pkg::lsma_fpu_req_t req_i,
  output lsma_pkg::lsma_fpu_rsp_t rsp_o
);
  import lsma_pkg::*;

  // working significand: carry bit, 53 bits, 54 guard bits
  localparam int          MW      = 108;
  localparam logic [11:0] MW_AMT  = 12'(MW);
  localparam logic [13:0] EXP_INF = 14'd2047;

  function automatic logic is_nan(logic [63:0] v);
    return (&v[62:52]) && (|v[51:0]);
  endfunction

  function automatic logic is_inf(logic [63:0] v);
    return (&v[62:52]) && !(|v[51:0]);
  endfunction

  function automatic logic is_zero(logic [63:0] v);
    return v[62:0] == 63'd0;
  endfunction

  function automatic logic [63:0] quiet(logic [63:0] v);
    return v | 64'h0008_0000_0000_0000;
  endfunction

  function automatic logic [52:0] mant(logic [63:0] v);
    return {|v[62:52], v[51:0]};
  endfunction

  function automatic logic [10:0] expo(logic [63:0] v);
    return (v[62:52] == 11'd0) ? 11'd1 : v[62:52];
  endfunction

  function automatic logic [3:0] lz8(logic [7:0] v);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) n = 4'(7 - i);
    end
    return n;
  endfunction

  lsma_fstate_e    fst_q, fst_d;
  logic [63:0]     a_q, a_d, x_q, x_d, b_q, b_d, p_q, p_d, res_q, res_d;
  logic [MW-1:0]   m_q, m_d, big_q, big_d;
  logic [13:0]     eb_q, eb_d;
  logic [11:0]     amt_q, amt_d;
  logic            sgn_q, sgn_d, sub_q, sub_d, phase_q, phase_d, done_q, done_d;
  logic [2:0]      mcnt_q, mcnt_d;
  logic [53:0]     pp_q, pp_d;

  // right shifter with sticky jam, up to 16 places a cycle
  logic [4:0]    sh_k;
  logic [MW-1:0] sh_mask, sh_m;
  logic [11:0]   sh_amt;
  always_comb begin
    sh_k    = (amt_q >= 12'd16) ? 5'd16 : amt_q[4:0];
    sh_mask = (MW'(1) << sh_k) - MW'(1);
    if (amt_q >= MW_AMT) begin
      sh_m   = {{(MW-1){1'b0}}, |m_q};
      sh_amt = 12'd0;
    end else begin
      sh_m   = (m_q >> sh_k) | MW'(|(m_q & sh_mask));
      sh_amt = amt_q - 12'(sh_k);
    end
  end

  // left normalize, up to 8 places a cycle
  logic [7:0]    nz_top;
  logic [3:0]    nz_n;
  logic [MW-1:0] nz_m;
  logic [13:0]   nz_eb;
  always_comb begin
    nz_top = m_q[MW-1 -: 8];
    nz_n   = (nz_top == 8'd0) ? 4'd8 : lz8(nz_top);
    nz_m   = m_q << nz_n;
    nz_eb  = eb_q - 14'(nz_n);
  end

  // round to nearest even and pack
  logic [52:0] r_mant, r_fin;
  logic        r_g, r_st, r_up, r_ovf;
  logic [53:0] r_sum;
  logic [13:0] r_eb;
  logic [63:0] r_bits;
  always_comb begin
    r_mant = m_q[MW-1 -: 53];
    r_g    = m_q[MW-54];
    r_st   = |m_q[MW-55:0];
    r_up   = r_g && (r_st || r_mant[0]);
    r_sum  = {1'b0, r_mant} + 54'(r_up);
    r_fin  = r_sum[53] ? r_sum[53:1] : r_sum[52:0];
    r_eb   = eb_q + 14'(r_sum[53]);
    r_ovf  = !r_eb[13] && (r_eb >= EXP_INF);
    if (r_ovf) r_bits = {sgn_q, 11'h7FF, 52'd0};
    else       r_bits = {sgn_q, (r_fin[52] ? r_eb[10:0] : 11'd0), r_fin[51:0]};
  end

  // partial product select: lo*lo, lo*hi, hi*lo, hi*hi
  logic [52:0] ma, mx;
  logic [26:0] mul_l, mul_r;
  logic [2:0]  pp_prev;
  logic [6:0]  pp_sh;
  always_comb begin
    ma      = mant(a_q);
    mx      = mant(x_q);
    mul_l   = mcnt_q[1] ? ma[52:26] : {1'b0, ma[25:0]};
    mul_r   = mcnt_q[0] ? mx[52:26] : {1'b0, mx[25:0]};
    pp_prev = mcnt_q - 3'd1;
    pp_sh   = (pp_prev[1] ? 7'd26 : 7'd0) + (pp_prev[0] ? 7'd26 : 7'd0) + 7'd2;
  end

  // alignment operands and sum
  logic          b_ge;
  logic [63:0]   big_v, sm_v;
  logic [MW-1:0] sum_v;
  always_comb begin
    b_ge  = b_q[62:0] >= p_q[62:0];
    big_v = b_ge ? b_q : p_q;
    sm_v  = b_ge ? p_q : b_q;
    sum_v = sub_q ? (big_q - m_q) : (big_q + m_q);
  end

  // sequencer
  always_comb begin
    fst_d   = fst_q;
    a_d     = a_q;
    x_d     = x_q;
    b_d     = b_q;
    p_d     = p_q;
    res_d   = res_q;
    m_d     = m_q;
    big_d   = big_q;
    eb_d    = eb_q;
    amt_d   = amt_q;
    sgn_d   = sgn_q;
    sub_d   = sub_q;
    phase_d = phase_q;
    mcnt_d  = mcnt_q;
    pp_d    = pp_q;
    done_d  = 1'b0;
    case (fst_q)
      F_IDLE: begin
        if (req_i.start) begin
          a_d   = req_i.coef;
          x_d   = req_i.xval;
          b_d   = req_i.bval;
          fst_d = F_MSET;
        end
      end
      F_MSET: begin
        fst_d = F_ASET;
        if (is_nan(a_q))      p_d = quiet(a_q);
        else if (is_nan(x_q)) p_d = quiet(x_q);
        else if ((is_inf(a_q) && is_zero(x_q)) || (is_zero(a_q) && is_inf(x_q)))
          p_d = DEFAULT_NAN;
        else if (is_inf(a_q) || is_inf(x_q))
          p_d = {a_q[63] ^ x_q[63], 11'h7FF, 52'd0};
        else if (is_zero(a_q) || is_zero(x_q))
          p_d = {a_q[63] ^ x_q[63], 63'd0};
        else begin
          m_d     = '0;
          sgn_d   = a_q[63] ^ x_q[63];
          eb_d    = 14'(expo(a_q)) + 14'(expo(x_q)) - 14'd1022;
          mcnt_d  = 3'd0;
          phase_d = 1'b0;
          fst_d   = F_MUL;
        end
      end
      F_MUL: begin
        // multiply into pp_q, then accumulate pp_q into m_q
        pp_d   = mul_l * mul_r;
        mcnt_d = mcnt_q + 3'd1;
        if (mcnt_q != 3'd0) m_d = m_q + (MW'(pp_q) << pp_sh);
        if (mcnt_q == 3'd4) fst_d = F_NORM;
      end
      F_NORM: begin
        if (m_q[MW-1]) begin
          if (eb_q[13] || (eb_q == 14'd0)) begin
            amt_d = 12'(14'd1 - eb_q);
            eb_d  = 14'd1;
            fst_d = F_DEN;
          end else begin
            fst_d = F_RND;
          end
        end else begin
          m_d  = nz_m;
          eb_d = nz_eb;
        end
      end
      F_DEN: begin
        if (amt_q == 12'd0) fst_d = F_RND;
        else begin
          m_d   = sh_m;
          amt_d = sh_amt;
        end
      end
      F_RND: begin
        if (phase_q) begin
          res_d = r_bits;
          fst_d = F_DONE;
        end else begin
          p_d   = r_bits;
          fst_d = F_ASET;
        end
      end
      F_ASET: begin
        fst_d = F_DONE;
        if (is_nan(b_q))      res_d = quiet(b_q);
        else if (is_nan(p_q)) res_d = quiet(p_q);
        else if (is_inf(b_q) && is_inf(p_q) && (b_q[63] != p_q[63])) res_d = DEFAULT_NAN;
        else if (is_inf(b_q))  res_d = b_q;
        else if (is_inf(p_q))  res_d = p_q;
        else if (is_zero(b_q) && is_zero(p_q)) res_d = {b_q[63] & p_q[63], 63'd0};
        else if (is_zero(p_q)) res_d = b_q;
        else if (is_zero(b_q)) res_d = p_q;
        else begin
          big_d   = {1'b0, mant(big_v), 54'd0};
          m_d     = {1'b0, mant(sm_v), 54'd0};
          amt_d   = 12'(expo(big_v) - expo(sm_v));
          sgn_d   = big_v[63];
          sub_d   = b_q[63] ^ p_q[63];
          eb_d    = 14'(expo(big_v)) + 14'd1;
          phase_d = 1'b1;
          fst_d   = F_ALIGN;
        end
      end
      F_ALIGN: begin
        if (amt_q == 12'd0) fst_d = F_ADD;
        else begin
          m_d   = sh_m;
          amt_d = sh_amt;
        end
      end
      F_ADD: begin
        if (sum_v == '0) begin
          res_d = 64'd0;
          fst_d = F_DONE;
        end else begin
          m_d   = sum_v;
          fst_d = F_NORM;
        end
      end
      F_DONE: begin
        done_d = 1'b1;
        fst_d  = F_IDLE;
      end
      default: fst_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q  <= F_IDLE;
      done_q <= 1'b0;
    end else begin
      fst_q  <= fst_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    x_q     <= x_d;
    b_q     <= b_d;
    p_q     <= p_d;
    res_q   <= res_d;
    m_q     <= m_d;
    big_q   <= big_d;
    eb_q    <= eb_d;
    amt_q   <= amt_d;
    sgn_q   <= sgn_d;
    sub_q   <= sub_d;
    phase_q <= phase_d;
    mcnt_q  <= mcnt_d;
    pp_q    <= pp_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  `LSMA_ASSERT(a_done_pulse, rsp_o.done |=> !rsp_o.done)
  `LSMA_ASSERT_IMP(a_norm_nonzero, fst_q == F_NORM, m_q != '0)
  `LSMA_ASSERT_IMP(a_rnd_exp, fst_q == F_RND, !eb_q[13] && (eb_q != 14'd0))

endmodule

// ===== rtl/ldu_sparse_matvec_accumulate.sv =====
// Sparse matrix-vector accumulate, b += A*x, over on-chip x and b stores.
// Input channel: in_valid_i / in_stall_o carry one word per item (opcode,
// vertex indices, component, two double coefficients). Element address is
// vertex * components_in_use (clamped to 1..MAX_COMPONENTS) + component.
// Output channel: out_valid_o / out_stall_i return one word per read item.
// Items are handled one at a time; in_stall_o is high while an item is busy.
//   load x / load b / ignored item: handled in the dispatch state
//   read b: store read, then the output register
//   diagonal: store read, then the iterative multiply-add unit
//     (4 partial products, 8-bit normalize steps, 16-bit align steps)
//   edge: a second term through the unit when lower terms are enabled
// A finished read word waits in the output register while out_stall_i is
// high; the next item is still accepted, and only another read waits.
// Reset empties the pipeline and sets components_in_use = 1,
// lower_enabled = 1. Store contents are undefined until loaded.
// Configuration: APB port, register 0 at 0x0, register 1 at 0x4.
module ldu_sparse_matvec_accumulate #(
  parameter int unsigned MAX_VERTICES   = lsma_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_COMPONENTS = lsma_pkg::MAX_COMPONENTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [11:0] row_vertex_i,
  input  logic [11:0] col_vertex_i,
  input  logic [1:0]  component_i,
  input  logic [63:0] value_a_i,
  input  logic [63:0] value_b_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_value_o,
  output logic [11:0] result_vertex_o,
  output logic [1:0]  result_component_o
);
  import lsma_pkg::*;

  localparam int unsigned DEPTH = MAX_VERTICES * MAX_COMPONENTS;
  localparam int          AW    = $clog2(DEPTH);
  localparam int          EW    = (AW > 16) ? AW : 16;
  localparam logic [4:0]  MAXC5 = 5'(MAX_COMPONENTS);

  typedef struct packed {
    logic          ok;
    logic [AW-1:0] addr;
  } elem_t;

  function automatic elem_t elem_of(logic [11:0] v, logic [1:0] c, logic [2:0] s);
    elem_t         e;
    logic [EW-1:0] lin;
    lin    = EW'(v) * EW'(s) + EW'(c);
    e.ok   = (32'(v) < 32'(MAX_VERTICES)) && ({1'b0, c} < s);
    e.addr = lin[AW-1:0];
    return e;
  endfunction

  // configuration registers
  logic [2:0] comps_q;
  logic       lower_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_LOWER) ? {31'd0, lower_q} : {29'd0, comps_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comps_q <= 3'd1;
      lower_q <= 1'b1;
    end else if (cfg_we) begin
      if (paddr[2] == REG_COMPONENTS) comps_q <= pwdata[2:0];
      else                            lower_q <= pwdata[0];
    end
  end

  // effective stride
  logic [2:0] stride;
  always_comb begin
    if (comps_q == 3'd0)                stride = 3'd1;
    else if ({2'b0, comps_q} > MAXC5)   stride = 3'(MAX_COMPONENTS);
    else                                stride = comps_q;
  end

  elem_t row_e, col_e;
  assign row_e = elem_of(row_vertex_i, component_i, stride);
  assign col_e = elem_of(col_vertex_i, component_i, stride);

  // item registers
  logic [2:0]    op_q;
  logic [11:0]   row_q;
  logic [1:0]    comp_q;
  logic [63:0]   va_q, vb_q, coef_q;
  logic [AW-1:0] ra_q, ca_q, dst_q, src_q;
  logic          rok_q, cok_q, half_q;

  lsma_state_e   state_q, state_d;
  lsma_fpu_req_t fpu_req;
  lsma_fpu_rsp_t fpu_rsp;

  logic in_accept, ld_first, ld_second, x_we, b_we, b_from_fpu, out_load;
  logic out_valid_q;

  // vector store read data
  logic [63:0]   x_rd_q, b_rd_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // sequencer
  always_comb begin
    state_d       = state_q;
    ld_first      = 1'b0;
    ld_second     = 1'b0;
    x_we          = 1'b0;
    b_we          = 1'b0;
    b_from_fpu    = 1'b0;
    out_load      = 1'b0;
    fpu_req.start = 1'b0;
    fpu_req.coef  = coef_q;
    fpu_req.xval  = x_rd_q;
    fpu_req.bval  = b_rd_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        case (op_q)
          OP_LOAD_X: x_we = rok_q;
          OP_LOAD_B: b_we = rok_q;
          OP_DIAG: begin
            if (rok_q) begin
              ld_first = 1'b1;
              state_d  = S_READ;
            end
          end
          OP_EDGE: begin
            if (rok_q && cok_q) begin
              ld_first = 1'b1;
              state_d  = S_READ;
            end
          end
          OP_READ: begin
            ld_first = 1'b1;
            state_d  = S_READ;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_READ: begin
        state_d = (op_q == OP_READ) ? S_RDOUT : S_FSTART;
      end
      S_FSTART: begin
        fpu_req.start = 1'b1;
        state_d       = S_FWAIT;
      end
      S_FWAIT: begin
        if (fpu_rsp.done) begin
          b_we       = 1'b1;
          b_from_fpu = 1'b1;
          if ((op_q == OP_EDGE) && !half_q && lower_q) begin
            ld_second = 1'b1;
            state_d   = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RDOUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_first)       half_q <= 1'b0;
      else if (ld_second) half_q <= 1'b1;
    end
  end

  // item capture and term operands
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= opcode_i;
      row_q  <= row_vertex_i;
      comp_q <= component_i;
      va_q   <= value_a_i;
      vb_q   <= value_b_i;
      ra_q   <= row_e.addr;
      rok_q  <= row_e.ok;
      ca_q   <= col_e.addr;
      cok_q  <= col_e.ok;
    end
    if (ld_first) begin
      dst_q  <= ra_q;
      src_q  <= (op_q == OP_EDGE) ? ca_q : ra_q;
      coef_q <= va_q;
    end else if (ld_second) begin
      dst_q  <= ca_q;
      src_q  <= ra_q;
      coef_q <= vb_q;
    end
  end

  // vector stores, registered reads
  logic [63:0]   x_mem [DEPTH];
  logic [63:0]   b_mem [DEPTH];
  logic [63:0]   b_wdata;
  logic [AW-1:0] b_waddr;

  assign b_wdata = b_from_fpu ? fpu_rsp.result : va_q;
  assign b_waddr = b_from_fpu ? dst_q : ra_q;

  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[ra_q] <= va_q;
    x_rd_q <= x_mem[src_q];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) b_mem[b_waddr] <= b_wdata;
    b_rd_q <= b_mem[dst_q];
  end

  // multiply-add unit
  lsma_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .rsp_o  (fpu_rsp)
  );

  // output register
  logic [63:0] res_value_q;
  logic [11:0] res_vertex_q;
  logic [1:0]  res_comp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_value_q  <= rok_q ? b_rd_q : 64'd0;
      res_vertex_q <= row_q;
      res_comp_q   <= comp_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_value_o     = res_value_q;
  assign result_vertex_o    = res_vertex_q;
  assign result_component_o = res_comp_q;

  `LSMA_ASSERT_IMP(a_done_in_wait, fpu_rsp.done, state_q == S_FWAIT)
  `LSMA_ASSERT_IMP(a_half_edge, (state_q == S_FWAIT) && half_q, (op_q == OP_EDGE) && lower_q)
  `LSMA_ASSERT_IMP(a_out_free, out_load, !out_valid_q || !out_stall_i)

endmodule

// ===== tb/sv/tb_ldu_sparse_matvec_accumulate.sv =====
module tb_ldu_sparse_matvec_accumulate;
  timeunit 1ns;
  timeprecision 1ps;
  import lsma_pkg::*;

  localparam int unsigned STORE_WORDS = MAX_VERTICES_DEF * MAX_COMPONENTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [11:0] row;
    logic [11:0] col;
    logic [1:0]  comp;
    logic [63:0] va;
    logic [63:0] vb;
  } item_t;

  typedef struct {
    logic [63:0] value;
    logic [11:0] vertex;
    logic [1:0]  comp;
  } read_word_t;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_stall_o;
  logic [2:0]  opcode_i;
  logic [11:0] row_vertex_i, col_vertex_i;
  logic [1:0]  component_i;
  logic [63:0] value_a_i, value_b_i;
  logic        out_valid_o, out_stall_i;
  logic [63:0] result_value_o;
  logic [11:0] result_vertex_o;
  logic [1:0]  result_component_o;

  ldu_sparse_matvec_accumulate u_dut (.*);

  // predictor state
  logic [63:0] x_store [STORE_WORDS];
  logic [63:0] b_store [STORE_WORDS];
  logic [2:0]  cfg_components = 3'd1;
  logic        cfg_lower = 1'b1;
  // which entries the stimulus has loaded so far
  bit          x_loaded [STORE_WORDS];
  bit          b_loaded [STORE_WORDS];

  item_t       pending_items[$];
  read_word_t  expected_reads[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0, out_hold = 0;
  bit          calm = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned stride_of(logic [2:0] c);
    if (c == 0) return 1;
    if (c > MAX_COMPONENTS_DEF) return MAX_COMPONENTS_DEF;
    return c;
  endfunction

  function automatic bit elem_addr(logic [11:0] v, logic [1:0] c, output int unsigned a);
    int unsigned s;
    s = stride_of(cfg_components);
    a = 0;
    if (c >= s) return 0;
    a = v * s + c;
    return 1;
  endfunction

  // b += coef * x, product and sum rounded separately
  function automatic logic [63:0] mul_add(logic [63:0] coef, logic [63:0] xv, logic [63:0] bv);
    real p, s;
    p = $bitstoreal(coef) * $bitstoreal(xv);
    s = $bitstoreal(bv) + p;
    return $realtobits(s);
  endfunction

  function automatic bit is_nan(logic [63:0] d);
    return d[62:52] == 11'h7FF && d[51:0] != 0;
  endfunction

  task automatic apply_item(item_t it);
    int unsigned ra, ca;
    bit rok, cok;
    read_word_t w;
    rok = elem_addr(it.row, it.comp, ra);
    cok = elem_addr(it.col, it.comp, ca);
    case (it.op)
      OP_LOAD_X: if (rok) x_store[ra] = it.va;
      OP_LOAD_B: if (rok) b_store[ra] = it.va;
      OP_DIAG:   if (rok) b_store[ra] = mul_add(it.va, x_store[ra], b_store[ra]);
      OP_EDGE: begin
        if (rok && cok) begin
          b_store[ra] = mul_add(it.va, x_store[ca], b_store[ra]);
          if (cfg_lower) b_store[ca] = mul_add(it.vb, x_store[ra], b_store[ca]);
        end
      end
      OP_READ: begin
        w.value = rok ? b_store[ra] : 64'd0;
        w.vertex = it.row;
        w.comp = it.comp;
        expected_reads.push_back(w);
      end
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand_double();
    logic s;
    s = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return {s, 63'd0};
      2: return {s, 11'd0, 20'($urandom), $urandom};
      default: return {s, 11'($urandom_range(1003, 1043)), 20'($urandom), $urandom};
    endcase
  endfunction

  task automatic push_item(logic [2:0] op, logic [11:0] row, logic [11:0] col,
                           logic [1:0] comp, logic [63:0] va, logic [63:0] vb);
    item_t it;
    int unsigned a;
    it = '{op, row, col, comp, va, vb};
    if (elem_addr(row, comp, a)) begin
      if (op == OP_LOAD_X) x_loaded[a] = 1;
      if (op == OP_LOAD_B) b_loaded[a] = 1;
    end
    pending_items.push_back(it);
  endtask

  function automatic logic [11:0] pick_vertex();
    if ($urandom_range(0, 9) == 0) return 12'($urandom);
    if ($urandom_range(0, 19) == 0) return 12'hFFF;
    return 12'($urandom_range(0, 31));
  endfunction

  // random item; terms that would touch unloaded entries become loads
  task automatic push_random();
    logic [2:0] op;
    logic [11:0] row, col, tmp;
    logic [1:0] comp;
    int unsigned ra, ca, r, s;
    bit rok, cok;
    s = stride_of(cfg_components);
    r = $urandom_range(0, 99);
    if (r < 15) op = OP_LOAD_X;
    else if (r < 30) op = OP_LOAD_B;
    else if (r < 50) op = OP_DIAG;
    else if (r < 75) op = OP_EDGE;
    else if (r < 95) op = OP_READ;
    else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    row = pick_vertex();
    col = ($urandom_range(0, 9) == 0) ? row : pick_vertex();
    comp = ($urandom_range(0, 6) == 0) ? 2'($urandom) : 2'($urandom_range(0, s - 1));
    rok = elem_addr(row, comp, ra);
    cok = elem_addr(col, comp, ca);
    case (op)
      OP_DIAG: if (rok && !(x_loaded[ra] && b_loaded[ra]))
        op = x_loaded[ra] ? OP_LOAD_B : OP_LOAD_X;
      OP_READ: if (rok && !b_loaded[ra]) op = OP_LOAD_B;
      OP_EDGE: begin
        if (rok && cok) begin
          tmp = row;
          if (!x_loaded[ca]) begin
            op = OP_LOAD_X; row = col;
          end else if (!b_loaded[ra]) begin
            op = OP_LOAD_B;
          end else if (cfg_lower && !x_loaded[ra]) begin
            op = OP_LOAD_X;
          end else if (cfg_lower && !b_loaded[ca]) begin
            op = OP_LOAD_B; row = col;
          end
          if (op != OP_EDGE) col = tmp;
        end
      end
      default: ;
    endcase
    push_item(op, row, col, comp, rand_double(), rand_double());
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_reads.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input driver: accept at rising edge, drive at falling edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      apply_item(pending_items.pop_front());
      in_gap = calm ? 0 : $urandom_range(0, 13);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid_i <= 0;
    end else if (pending_items.size() > 0) begin
      in_valid_i <= 1;
      opcode_i <= pending_items[0].op;
      row_vertex_i <= pending_items[0].row;
      col_vertex_i <= pending_items[0].col;
      component_i <= pending_items[0].comp;
      value_a_i <= pending_items[0].va;
      value_b_i <= pending_items[0].vb;
    end else begin
      in_valid_i <= 0;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    read_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reads.size() == 0) begin
        errors++;
        $display("%0t: unexpected word value=%h vertex=%0d comp=%0d", $time,
                 result_value_o, result_vertex_o, result_component_o);
      end else begin
        w = expected_reads.pop_front();
        if (!(w.value === result_value_o || (is_nan(w.value) && is_nan(result_value_o)))) begin
          errors++;
          $display("%0t: value expected %h actual %h", $time, w.value, result_value_o);
        end
        if (w.vertex !== result_vertex_o) begin
          errors++;
          $display("%0t: vertex expected %0d actual %0d", $time, w.vertex, result_vertex_o);
        end
        if (w.comp !== result_component_o) begin
          errors++;
          $display("%0t: component expected %0d actual %0d", $time, w.comp,
                   result_component_o);
        end
      end
      out_hold = calm ? 0 : $urandom_range(0, 13);
    end
  end

  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_hold--;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= 0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [2:0] strides [9] = '{3'd4, 3'd4, 3'd2, 3'd3, 3'd1, 3'd0, 3'd7, 3'd5, 3'd1};
    bit         lowers  [9] = '{1, 0, 1, 0, 0, 1, 1, 0, 1};
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; opcode_i = 0; row_vertex_i = 0; col_vertex_i = 0;
    component_i = 0; value_a_i = 0; value_b_i = 0; out_stall_i = 0;
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: extremes, all-ones bits, invalid elements, self edge
    push_item(OP_LOAD_X, 12'd0, 12'hFFF, 2'd0, 64'h3FF0_0000_0000_0000, '1);
    push_item(OP_LOAD_B, 12'd0, 12'hFFF, 2'd0, '1, '1);
    push_item(OP_READ, 12'd0, 12'hFFF, 2'd0, '1, '1);
    push_item(OP_LOAD_B, 12'd0, 12'd0, 2'd0, 64'h4000_0000_0000_0000, 0);
    push_item(OP_LOAD_X, 12'hFFF, 12'd0, 2'd0, 64'h8000_0000_0000_0001, 0);
    push_item(OP_LOAD_B, 12'hFFF, 12'd0, 2'd0, 64'h7FEF_FFFF_FFFF_FFFF, 0);
    push_item(OP_DIAG, 12'd0, 12'd0, 2'd0, 64'hBFF8_0000_0000_0000, '1);
    push_item(OP_DIAG, 12'hFFF, 12'd0, 2'd0, 64'h0010_0000_0000_0000, 0);
    push_item(OP_EDGE, 12'd0, 12'hFFF, 2'd0, 64'h4010_0000_0000_0000,
              64'hC000_0000_0000_0000);
    push_item(OP_EDGE, 12'd0, 12'd0, 2'd0, 64'h3FE0_0000_0000_0000,
              64'h4008_0000_0000_0000);
    push_item(OP_EDGE, 12'd0, 12'hFFF, 2'd3, '1, '1);
    push_item(OP_LOAD_X, 12'd5, 12'd0, 2'd1, 64'h4000_0000_0000_0000, 0);
    push_item(OP_DIAG, 12'd5, 12'd0, 2'd2, 64'h4000_0000_0000_0000, 0);
    push_item(OP_READ, 12'd7, 12'd0, 2'd3, 0, 0);
    push_item(OP_UNUSED_LO, 12'd0, 12'd0, 2'd0, '1, '1);
    push_item(OP_UNUSED_HI, 12'hFFF, 12'hFFF, 2'd3, 0, 0);
    push_item(OP_READ, 12'd0, 12'd0, 2'd0, 0, 0);
    push_item(OP_READ, 12'hFFF, 12'd0, 2'd0, 0, 0);
    drain();

    // random phases over several register settings
    for (int p = 0; p < 9; p++) begin
      write_reg({REG_COMPONENTS, 2'b00}, 32'(strides[p]));
      write_reg({REG_LOWER, 2'b00}, 32'(lowers[p]));
      cfg_components = strides[p];
      cfg_lower = lowers[p];
      calm = (p % 3 == 2);
      for (int i = 0; i < 190; i++) push_random();
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lsma_pkg.sv
rtl/lsma_fpu.sv
rtl/ldu_sparse_matvec_accumulate.sv
tb/sv/tb_ldu_sparse_matvec_accumulate.sv
